[rtl/core/nnis_pkg.sv]
// Shared constants, types and helpers of the nearest-neighbor image scaler.
`default_nettype none
package nnis_pkg;

	localparam int MAX_SRC_WIDTH  = 256;
	localparam int MAX_SRC_HEIGHT = 256;
	localparam int PIXEL_BITS     = 32;
	localparam int FRACTION_BITS  = 16;

	// Port and register widths fixed by the interface definition
	localparam int PORT_PIXEL_BITS = 32;
	localparam int SRC_SIZE_BITS   = 9;
	localparam int DST_SIZE_BITS   = 13;
	localparam int CFG_DATA_BITS   = 13;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int TARGET_MAX      = 4096;
	localparam int COUNT_BITS      = 12;
	localparam int ACC_BITS        = 26;
	localparam int STEP_BITS       = 25;
	localparam int CFG_RESET       = 256;

	localparam int COL_BITS    = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
	localparam int ROW_BITS    = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
	localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int INT_BITS    = ACC_BITS - FRACTION_BITS;
	localparam int REM_BITS    = DST_SIZE_BITS + 1;
	localparam int ITER_BITS   = $clog2(STEP_BITS);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_EMIT = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		JOB_COL_STEP  = 2'd0,
		JOB_ROW_STEP  = 2'd1,
		JOB_COL_RATIO = 2'd2,
		JOB_ROW_RATIO = 2'd3
	} div_job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ITER,
		ST_STORE,
		ST_APPLY
	} ctrl_state_t;

	typedef struct packed {
		logic     cfg_write;
		logic     load_px;
		logic     emit;
		logic     div_load;
		logic     div_step;
		logic     div_store;
		logic     apply;
		div_job_t job;
	} nnis_cmd_t;

	typedef struct packed {
		logic out_valid;
	} nnis_status_t;

	// Start offset of an accumulator: 1 << (FRACTION_BITS - ratio), exponent floored at 0
	function automatic logic [ACC_BITS-1:0] start_of(input logic [STEP_BITS-1:0] ratio);
		logic [ACC_BITS-1:0] one;
		one = ACC_BITS'(1);
		if (ratio < STEP_BITS'(FRACTION_BITS)) begin
			return one << (FRACTION_BITS - int'(ratio));
		end
		return one;
	endfunction

	localparam int RESET_SW = (CFG_RESET > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : CFG_RESET;
	localparam int RESET_SH = (CFG_RESET > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : CFG_RESET;
	localparam logic [STEP_BITS-1:0] RESET_COL_STEP =
		STEP_BITS'((RESET_SW << FRACTION_BITS) / CFG_RESET);
	localparam logic [STEP_BITS-1:0] RESET_ROW_STEP =
		STEP_BITS'((RESET_SH << FRACTION_BITS) / CFG_RESET);
	localparam logic [ACC_BITS-1:0] RESET_COL_START =
		start_of(STEP_BITS'(CFG_RESET / RESET_SW));
	localparam logic [ACC_BITS-1:0] RESET_ROW_START =
		start_of(STEP_BITS'(CFG_RESET / RESET_SH));

endpackage
`default_nettype wire

[rtl/core/nnis_req_if.sv]
// Request channel: load and emit items.
`default_nettype none
interface nnis_req_if;
	import nnis_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [PORT_PIXEL_BITS-1:0] src_pixel;
	modport source (output valid, req_type, src_pixel, input ready);
	modport sink (input valid, req_type, src_pixel, output ready);
endinterface
`default_nettype wire

[rtl/core/nnis_res_if.sv]
// Result channel: destination pixels with row and frame end marks.
`default_nettype none
interface nnis_res_if;
	import nnis_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [PORT_PIXEL_BITS-1:0] dst_pixel;
	logic                       row_end;
	logic                       frame_end;
	modport source (output valid, dst_pixel, row_end, frame_end, input ready);
	modport sink (input valid, dst_pixel, row_end, frame_end, output ready);
endinterface
`default_nettype wire

[rtl/core/nnis_cfg_if.sv]
// Configuration write channel: register index and write data.
`default_nettype none
interface nnis_cfg_if;
	import nnis_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/nnis_ctrl.sv]
// Controller: handshakes and the sequencer of the coefficient divider.
`default_nettype none
module nnis_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	input  wire logic                  req_type,
	output logic                       req_ready,
	input  wire logic                  res_ready,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire nnis_pkg::nnis_status_t status,
	output nnis_pkg::nnis_cmd_t        cmd
);
	import nnis_pkg::*;

	ctrl_state_t           state_q, state_next;
	div_job_t              job_q;
	logic [ITER_BITS-1:0]  iter_q;
	logic                  iter_last;
	logic                  out_blocked;
	logic                  take;

	assign iter_last   = (iter_q == ITER_BITS'(STEP_BITS - 1));
	assign out_blocked = status.out_valid && !res_ready;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:  if (cfg_valid) state_next = ST_LOAD;
			ST_LOAD:  state_next = ST_ITER;
			ST_ITER:  if (iter_last) state_next = ST_STORE;
			ST_STORE: state_next = (job_q == JOB_ROW_RATIO) ? ST_APPLY : ST_LOAD;
			ST_APPLY: state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cfg_ready = (state_q == ST_IDLE);
		req_ready = (state_q == ST_IDLE) && !cfg_valid && !out_blocked;
		take      = req_valid && req_ready;
		cmd           = '0;
		cmd.cfg_write = cfg_valid && cfg_ready;
		cmd.load_px   = take && (req_type == REQ_LOAD);
		cmd.emit      = take && (req_type == REQ_EMIT);
		cmd.div_load  = (state_q == ST_LOAD);
		cmd.div_step  = (state_q == ST_ITER);
		cmd.div_store = (state_q == ST_STORE);
		cmd.apply     = (state_q == ST_APPLY);
		cmd.job       = job_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= JOB_COL_STEP;
			iter_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_IDLE) begin
				job_q <= JOB_COL_STEP;
			end else if (state_q == ST_STORE) begin
				job_q <= div_job_t'(job_q + 2'd1);
			end
			if (state_q == ST_ITER) begin
				iter_q <= iter_q + ITER_BITS'(1);
			end else begin
				iter_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/nnis_datapath.sv]
// Datapath: configuration, frame store, position accumulators and divider.
`default_nettype none
module nnis_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire nnis_pkg::nnis_cmd_t                  cmd,
	output nnis_pkg::nnis_status_t                    status,
	input  wire logic [nnis_pkg::PORT_PIXEL_BITS-1:0] src_pixel,
	input  wire logic [nnis_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [nnis_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                 res_ready,
	output logic                                      res_valid,
	output logic [nnis_pkg::PORT_PIXEL_BITS-1:0]      dst_pixel,
	output logic                                      row_end,
	output logic                                      frame_end
);
	import nnis_pkg::*;

	// Configuration registers
	logic [SRC_SIZE_BITS-1:0] src_w_q, src_h_q;
	logic [DST_SIZE_BITS-1:0] dst_w_q, dst_h_q;
	logic [SRC_SIZE_BITS-1:0] eff_sw, eff_sh;
	logic [DST_SIZE_BITS-1:0] eff_tw, eff_th;

	// Coefficients of the current configuration and the live ones
	logic [STEP_BITS-1:0] fresh_col_step_q, fresh_row_step_q;
	logic [ACC_BITS-1:0]  fresh_col_start_q, fresh_row_start_q;
	logic [STEP_BITS-1:0] col_step_q, row_step_q;
	logic [ACC_BITS-1:0]  col_acc_q, row_acc_q;
	logic [COUNT_BITS-1:0] out_col_q, out_row_q;
	logic [ADDR_BITS-1:0]  load_idx_q;

	// Divider
	logic [STEP_BITS-1:0]     quo_q, dvd;
	logic [DST_SIZE_BITS-1:0] rem_q, dvs_q, dvs;
	logic [REM_BITS-1:0]      rem_shift;
	logic                     rem_ge;

	// Frame store and result register
	logic [PIXEL_BITS-1:0] store_mem [STORE_DEPTH];
	logic [PIXEL_BITS-1:0] rd_q;
	logic                  out_valid_q, row_end_q, frame_end_q;

	logic [INT_BITS-1:0]  r_raw, c_raw;
	logic [ROW_BITS-1:0]  r_idx;
	logic [COL_BITS-1:0]  c_idx;
	logic [ADDR_BITS-1:0] rd_addr;
	logic [2*SRC_SIZE_BITS-1:0] total;
	logic                 col_last, row_last, at_origin;

	function automatic logic [SRC_SIZE_BITS-1:0] clamp_src(
		input logic [SRC_SIZE_BITS-1:0] v, input int max_v);
		if (v == '0) return SRC_SIZE_BITS'(1);
		if (int'(v) > max_v) return SRC_SIZE_BITS'(max_v);
		return v;
	endfunction

	function automatic logic [DST_SIZE_BITS-1:0] clamp_dst(input logic [DST_SIZE_BITS-1:0] v);
		if (v == '0) return DST_SIZE_BITS'(1);
		if (int'(v) > TARGET_MAX) return DST_SIZE_BITS'(TARGET_MAX);
		return v;
	endfunction

	assign eff_sw = clamp_src(src_w_q, MAX_SRC_WIDTH);
	assign eff_sh = clamp_src(src_h_q, MAX_SRC_HEIGHT);
	assign eff_tw = clamp_dst(dst_w_q);
	assign eff_th = clamp_dst(dst_h_q);

	assign at_origin = (out_row_q == '0) && (out_col_q == '0);
	assign status.out_valid = out_valid_q;

	// Source position: integer part of the accumulators, clamped to the plane
	always_comb begin
		r_raw = row_acc_q[ACC_BITS-1:FRACTION_BITS];
		c_raw = col_acc_q[ACC_BITS-1:FRACTION_BITS];
		if (32'(r_raw) > 32'(eff_sh) - 32'd1) begin
			r_idx = ROW_BITS'(eff_sh - SRC_SIZE_BITS'(1));
		end else begin
			r_idx = ROW_BITS'(r_raw);
		end
		if (32'(c_raw) > 32'(eff_sw) - 32'd1) begin
			c_idx = COL_BITS'(eff_sw - SRC_SIZE_BITS'(1));
		end else begin
			c_idx = COL_BITS'(c_raw);
		end
		rd_addr  = ADDR_BITS'(ADDR_BITS'(r_idx) * ADDR_BITS'(eff_sw) + ADDR_BITS'(c_idx));
		col_last = 32'(out_col_q) >= 32'(eff_tw) - 32'd1;
		row_last = 32'(out_row_q) >= 32'(eff_th) - 32'd1;
		total    = (2*SRC_SIZE_BITS)'(eff_sw) * (2*SRC_SIZE_BITS)'(eff_sh);
	end

	// Divider operands for each coefficient job
	always_comb begin
		unique case (cmd.job)
			JOB_COL_STEP: begin
				dvd = STEP_BITS'(eff_sw) << FRACTION_BITS;
				dvs = eff_tw;
			end
			JOB_ROW_STEP: begin
				dvd = STEP_BITS'(eff_sh) << FRACTION_BITS;
				dvs = eff_th;
			end
			JOB_COL_RATIO: begin
				dvd = STEP_BITS'(eff_tw);
				dvs = DST_SIZE_BITS'(eff_sw);
			end
			JOB_ROW_RATIO: begin
				dvd = STEP_BITS'(eff_th);
				dvs = DST_SIZE_BITS'(eff_sh);
			end
			default: begin
				dvd = '0;
				dvs = DST_SIZE_BITS'(1);
			end
		endcase
		rem_shift = {rem_q, quo_q[STEP_BITS-1]};
		rem_ge    = rem_shift >= REM_BITS'(dvs_q);
	end

	// Restoring division, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q <= dvd;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[STEP_BITS-2:0], rem_ge};
			if (rem_ge) begin
				rem_q <= DST_SIZE_BITS'(rem_shift - REM_BITS'(dvs_q));
			end else begin
				rem_q <= DST_SIZE_BITS'(rem_shift);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_SIZE_BITS'(CFG_RESET);
			src_h_q <= SRC_SIZE_BITS'(CFG_RESET);
			dst_w_q <= DST_SIZE_BITS'(CFG_RESET);
			dst_h_q <= DST_SIZE_BITS'(CFG_RESET);
		end else if (cmd.cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:  src_w_q <= cfg_data[SRC_SIZE_BITS-1:0];
				REG_SRC_HEIGHT: src_h_q <= cfg_data[SRC_SIZE_BITS-1:0];
				REG_DST_WIDTH:  dst_w_q <= cfg_data[DST_SIZE_BITS-1:0];
				REG_DST_HEIGHT: dst_h_q <= cfg_data[DST_SIZE_BITS-1:0];
				default:        src_w_q <= src_w_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_col_step_q  <= RESET_COL_STEP;
			fresh_row_step_q  <= RESET_ROW_STEP;
			fresh_col_start_q <= RESET_COL_START;
			fresh_row_start_q <= RESET_ROW_START;
		end else if (cmd.div_store) begin
			unique case (cmd.job)
				JOB_COL_STEP:  fresh_col_step_q  <= quo_q;
				JOB_ROW_STEP:  fresh_row_step_q  <= quo_q;
				JOB_COL_RATIO: fresh_col_start_q <= start_of(quo_q);
				JOB_ROW_RATIO: fresh_row_start_q <= start_of(quo_q);
				default:       fresh_col_step_q  <= fresh_col_step_q;
			endcase
		end
	end

	// Destination walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_step_q <= RESET_COL_STEP;
			row_step_q <= RESET_ROW_STEP;
			col_acc_q  <= RESET_COL_START;
			row_acc_q  <= RESET_ROW_START;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if (cmd.apply) begin
			if (at_origin) begin
				col_step_q <= fresh_col_step_q;
				row_step_q <= fresh_row_step_q;
				col_acc_q  <= fresh_col_start_q;
				row_acc_q  <= fresh_row_start_q;
			end
		end else if (cmd.emit) begin
			if (col_last) begin
				out_col_q <= '0;
				col_acc_q <= fresh_col_start_q;
				if (row_last) begin
					out_row_q  <= '0;
					col_step_q <= fresh_col_step_q;
					row_step_q <= fresh_row_step_q;
					row_acc_q  <= fresh_row_start_q;
				end else begin
					out_row_q <= out_row_q + COUNT_BITS'(1);
					row_acc_q <= ACC_BITS'(row_acc_q + ACC_BITS'(row_step_q));
				end
			end else begin
				out_col_q <= out_col_q + COUNT_BITS'(1);
				col_acc_q <= ACC_BITS'(col_acc_q + ACC_BITS'(col_step_q));
			end
		end
	end

	// Load pointer wraps after the last source pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q <= '0;
		end else if (cmd.load_px) begin
			if (32'(load_idx_q) + 32'd1 >= 32'(total)) begin
				load_idx_q <= '0;
			end else begin
				load_idx_q <= load_idx_q + ADDR_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_px) begin
			store_mem[load_idx_q] <= src_pixel[PIXEL_BITS-1:0];
		end
		if (cmd.emit) begin
			rd_q <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			row_end_q   <= col_last;
			frame_end_q <= col_last && row_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign dst_pixel = PORT_PIXEL_BITS'(rd_q);
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule
`default_nettype wire

[rtl/core/nearest_neighbour_image_scaler_top.sv]
// Top level of the nearest-neighbor image scaler.
//
//   channel | direction | payload                          | completes when
//   --------+-----------+----------------------------------+--------------------
//   req     | in        | req_type, src_pixel              | req.valid & req.ready
//   res     | out       | dst_pixel, row_end, frame_end    | res.valid & res.ready
//   cfg     | in        | index, data                      | cfg.valid & cfg.ready
//
// Items may follow every cycle unless a result stall or a write blocks them.
// An emit reads the frame store at its accept edge into the result register.
// A configuration write starts a coefficient pass: four divisions on a shared
// restoring divider (load, iterate, store states each), then an apply state;
// no item or further write is taken during it. No clearing pass after reset.
// A stalled result holds the result register and blocks items until taken.
`default_nettype none
module nearest_neighbour_image_scaler_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nnis_req_if.sink   req,
	nnis_res_if.source res,
	nnis_cfg_if.sink   cfg
);
	import nnis_pkg::*;

	// Command and status between the controller and the datapath
	nnis_cmd_t    cmd;
	nnis_status_t status;

	// Controller: accept items, sequence the coefficient divisions
	nnis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.res_ready (res.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: store pixels, walk the destination plane, hold the result
	nnis_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.src_pixel (req.src_pixel),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res_ready (res.ready),
		.res_valid (res.valid),
		.dst_pixel (res.dst_pixel),
		.row_end   (res.row_end),
		.frame_end (res.frame_end)
	);

endmodule
`default_nettype wire
